FILE: design/dtt_pkg.sv
package dtt_pkg;
  localparam int ENTRIES = 16;
  localparam int IDX_W = 4;
  localparam int TIME_W = 48;
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    ACT_POST = 3'd0,
    ACT_CANCEL = 3'd1,
    ACT_TICK = 3'd2,
    ACT_QUERY = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef struct packed {
    logic [31:0] id;
    logic [TIME_W-1:0] deadline;
  } slot_t;

  typedef struct packed {
    logic status;
    logic wake;
    logic fired_valid;
    logic [31:0] fired_id;
    logic [TIME_W-1:0] wait_ms;
    logic found;
    logic [CNT_W-1:0] pending_count;
    logic [CNT_W-1:0] repeat_count;
    logic last;
  } result_t;
endpackage

FILE: design/deadline_timer_table_top.sv
// table of sixteen one-shot timers; every command is accepted once the previous one has
// loaded its last result and is carried out as a scan of the slot memory at one entry per
// cycle, an update step and a load of the result; a tick adds, per fired timer, a scan for
// the lowest due id and a load; a result held by the receiver stalls the block
module deadline_timer_table_top
  import dtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action, timer_id, deadline_ms, repeat_req, now_ms
  input  logic [135:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, wake, fired_valid, fired_id, wait_ms, found, pending_count, repeat_count
  output logic [103:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  logic [15:0] idle_r;
  logic we;
  logic [IDX_W-1:0] wa, ra;
  slot_t wd, rd;
  result_t res;
  logic res_valid, res_ready;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) idle_r <= 16'd1000;
    else if (cfg_valid) idle_r <= cfg_data;
  end

  dtt_slot_ram u_ram (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd)
  );

  dtt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .idle_wait(idle_r),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .act(s_axis_tdata[2:0]), .tid(s_axis_tdata[34:3]), .dl(s_axis_tdata[82:35]),
    .rr(s_axis_tdata[83]), .now(s_axis_tdata[131:84]),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .ram_we(we), .ram_waddr(wa), .ram_wdata(wd), .ram_raddr(ra), .ram_rdata(rd)
  );

  assign res_ready = m_axis_tready;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {6'b0, res.repeat_count, res.pending_count, res.found,
                         res.wait_ms, res.fired_id, res.fired_valid, res.wake,
                         res.status};
endmodule

FILE: design/dtt_slot_ram.sv
module dtt_slot_ram
  import dtt_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  slot_t            wdata,
  input  logic [IDX_W-1:0] raddr,
  output slot_t            rdata
);
  slot_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/dtt_ctrl.sv
module dtt_ctrl
  import dtt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      idle_wait,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       act,
  input  logic [31:0]      tid,
  input  logic [TIME_W-1:0] dl,
  input  logic             rr,
  input  logic [TIME_W-1:0] now,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output slot_t            ram_wdata,
  output logic [IDX_W-1:0] ram_raddr,
  input  slot_t            ram_rdata
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EXEC = 5'b00100,
    S_FIRE = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r;
  logic [ENTRIES-1:0] pend_r, rep_r, due_r;
  logic [TIME_W-1:0] next_dl_r;
  logic next_v_r;
  logic [2:0] act_r;
  logic [31:0] tid_r;
  logic [TIME_W-1:0] dl_r, now_r;
  logic rr_r;
  logic [IDX_W:0] cnt_r;
  logic scan_rd_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic hit_r, free_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r;
  logic [TIME_W-1:0] hit_dl_r;
  logic best_v_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [31:0] best_id_r;
  logic fire_r;
  logic nv_r;
  logic [TIME_W-1:0] nd_r;
  logic st_r, wk_r, fd_r;
  logic [TIME_W-1:0] wait_r;
  result_t res_r;
  logic res_v_r;
  logic occ, scan_issue, scan_done, res_load;
  logic [CNT_W-1:0] pc, rc;

  assign in_ready = (state_r == S_IDLE);
  assign res_valid = res_v_r;
  assign res = res_r;
  assign ram_raddr = cnt_r[IDX_W-1:0];

  always_comb begin
    pc = '0;
    rc = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      pc = pc + CNT_W'(pend_r[i]);
      rc = rc + CNT_W'(rep_r[i]);
    end
  end

  assign occ = pend_r[rd_idx_r] | rep_r[rd_idx_r];
  assign scan_issue = (state_r == S_SCAN || state_r == S_FIRE) &&
                      (cnt_r != (IDX_W+1)'(ENTRIES));
  assign scan_done = (cnt_r == (IDX_W+1)'(ENTRIES)) && !scan_rd_r;
  assign res_load = (state_r == S_EMIT) && (!res_v_r || res_ready);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = hit_r ? hit_idx_r : free_idx_r;
    ram_wdata.id = tid_r;
    ram_wdata.deadline = dl_r;
    if (state_r == S_EXEC && act_r == ACT_POST && (hit_r || free_r)) begin
      if (!hit_r || !pend_r[hit_idx_r] || dl_r < hit_dl_r) begin
        ram_we = 1'b1;
      end
    end
  end

  // result register, one transfer held at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (res_load) begin
      res_v_r <= 1'b1;
      res_r <= '{status: st_r, wake: wk_r, fired_valid: fire_r,
                 fired_id: fire_r ? best_id_r : 32'd0, wait_ms: wait_r, found: fd_r,
                 pending_count: pc, repeat_count: rc, last: (due_r == '0)};
    end else if (res_ready) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r <= '0;
      rep_r <= '0;
      due_r <= '0;
      next_v_r <= 1'b0;
      next_dl_r <= '0;
      scan_rd_r <= 1'b0;
      fire_r <= 1'b0;
    end else begin
      scan_rd_r <= scan_issue;
      rd_idx_r <= cnt_r[IDX_W-1:0];
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r <= act;
            tid_r <= tid;
            dl_r <= dl;
            rr_r <= rr;
            now_r <= now;
            cnt_r <= '0;
            hit_r <= 1'b0;
            free_r <= 1'b0;
            nv_r <= 1'b0;
            nd_r <= '0;
            due_r <= '0;
            fire_r <= 1'b0;
            st_r <= 1'b0;
            wk_r <= 1'b0;
            fd_r <= 1'b0;
            wait_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_rd_r) begin
            if (act_r == ACT_TICK) begin
              if (pend_r[rd_idx_r]) begin
                if (ram_rdata.deadline <= now_r) begin
                  due_r[rd_idx_r] <= 1'b1;
                end else if (!nv_r || ram_rdata.deadline < nd_r) begin
                  nv_r <= 1'b1;
                  nd_r <= ram_rdata.deadline;
                end
              end
            end else begin
              if (occ && ram_rdata.id == tid_r && !hit_r) begin
                hit_r <= 1'b1;
                hit_idx_r <= rd_idx_r;
                hit_dl_r <= ram_rdata.deadline;
              end
              if (!occ && !free_r) begin
                free_r <= 1'b1;
                free_idx_r <= rd_idx_r;
              end
            end
          end
          if (scan_issue) begin
            cnt_r <= cnt_r + (IDX_W+1)'(1);
          end else if (scan_done) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (act_r)
            ACT_POST: begin
              if (!hit_r && !free_r) begin
                st_r <= 1'b1;
              end else begin
                pend_r[ram_waddr] <= 1'b1;
                if (!hit_r) rep_r[ram_waddr] <= rr_r;
                else if (rr_r) rep_r[ram_waddr] <= 1'b1;
                if (!next_v_r || dl_r < next_dl_r) begin
                  next_dl_r <= dl_r;
                  next_v_r <= 1'b1;
                  wk_r <= 1'b1;
                end
              end
            end
            ACT_CANCEL: begin
              if (hit_r) begin
                pend_r[hit_idx_r] <= 1'b0;
                rep_r[hit_idx_r] <= 1'b0;
              end
            end
            ACT_TICK: begin
              pend_r <= pend_r & ~due_r;
              next_v_r <= nv_r;
              next_dl_r <= nd_r;
              wait_r <= nv_r ? ((nd_r > now_r) ? nd_r - now_r : '0)
                             : TIME_W'(idle_wait);
            end
            ACT_QUERY: begin
              if (hit_r) fd_r <= rr_r ? rep_r[hit_idx_r] : pend_r[hit_idx_r];
            end
            ACT_CLEAR: begin
              pend_r <= '0;
              rep_r <= '0;
              next_v_r <= 1'b0;
              next_dl_r <= '0;
            end
            default: ;
          endcase
          cnt_r <= '0;
          best_v_r <= 1'b0;
          state_r <= (act_r == ACT_TICK && due_r != '0) ? S_FIRE : S_EMIT;
        end
        S_FIRE: begin
          // lowest id among the entries still due
          if (scan_rd_r && due_r[rd_idx_r] && (!best_v_r || ram_rdata.id < best_id_r)) begin
            best_v_r <= 1'b1;
            best_idx_r <= rd_idx_r;
            best_id_r <= ram_rdata.id;
          end
          if (scan_issue) begin
            cnt_r <= cnt_r + (IDX_W+1)'(1);
          end else if (scan_done) begin
            due_r[best_idx_r] <= 1'b0;
            fire_r <= 1'b1;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_load) begin
            if (due_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= '0;
              best_v_r <= 1'b0;
              state_r <= S_FIRE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
